// ===== hw/rtl/ship_rrip_replacement_defines.svh =====
// Assertion macros shared by the replacement engine.
`ifndef SHIP_RRIP_REPLACEMENT_DEFINES_SVH
`define SHIP_RRIP_REPLACEMENT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SHIP_ASSERT_IMPLIES(label, ck, rs, pre, post) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("assertion failed");
`define SHIP_ASSERT_NEXT(label, ck, rs, pre, post) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SHIP_ASSERT_IMPLIES(label, ck, rs, pre, post)
`define SHIP_ASSERT_NEXT(label, ck, rs, pre, post)
`endif

`endif

// ===== hw/rtl/ship_pkg.sv =====
package ship_pkg;

  localparam int SET_COUNT   = 2048;
  localparam int SET_W       = 11;
  localparam int WAY_IDX_W   = 4;
  localparam int ADDR_W      = 64;
  localparam int PC_SHIFT    = 2;
  localparam int PADDR_SHIFT = 12;
  localparam int CTR_W       = 2;

  localparam logic [CTR_W-1:0] CTR_TOP   = 2'd3;
  localparam logic [CTR_W-1:0] CTR_START = 2'd1;
  localparam logic [CTR_W-1:0] CTR_ZERO  = 2'd0;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic clear;
    logic latch;
    logic rd_row;
    logic scan;
    logic age_wr;
    logic rd_ctr;
    logic upd_wr;
    logic out_load;
  } ship_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_query;
    logic way_ok;
    logic out_free;
  } ship_stat_t;

endpackage

// ===== hw/rtl/ship_req_if.sv =====
interface ship_req_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [ship_pkg::SET_W-1:0]        set_index;
  logic [ship_pkg::WAY_IDX_W-1:0]    way_index;
  logic                              was_hit;
  logic [ship_pkg::ADDR_W-1:0]       pc;
  logic [ship_pkg::ADDR_W-1:0]       paddr;

  modport source (output valid, cmd, set_index, way_index, was_hit, pc, paddr, input ready);
  modport sink (input valid, cmd, set_index, way_index, was_hit, pc, paddr, output ready);
endinterface

// ===== hw/rtl/ship_rsp_if.sv =====
interface ship_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ship_pkg::WAY_IDX_W-1:0] victim_way;

  modport source (output valid, victim_way, input ready);
  modport sink (input valid, victim_way, output ready);
endinterface

// ===== hw/rtl/ship_ctrl.sv =====
`include "ship_rrip_replacement_defines.svh"

module ship_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  ship_pkg::ship_stat_t stat,
  output logic                ready,
  output ship_pkg::ship_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RD_ROW = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_AGE    = 7'b0010000,
    S_RD_CTR = 7'b0100000,
    S_UPD    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    ready      = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ready     = 1'b1;
        cmd.latch = req_valid;
        if (req_valid) begin
          state_next = S_RD_ROW;
        end
      end
      S_RD_ROW: begin
        cmd.rd_row = 1'b1;
        if (stat.is_query) begin
          state_next = S_SCAN;
        end else if (stat.way_ok) begin
          state_next = S_RD_CTR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = S_AGE;
      end
      S_AGE: begin
        if (stat.out_free) begin
          cmd.age_wr   = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RD_CTR: begin
        cmd.rd_ctr = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd_wr = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  `SHIP_ASSERT_NEXT(a_rst_to_clear, clk, 1'b0, rst, state == S_CLEAR)
  `SHIP_ASSERT_IMPLIES(a_load_when_free, clk, rst, cmd.out_load, stat.out_free)
  `SHIP_ASSERT_NEXT(a_accept_reads_row, clk, rst, req_valid && ready, state == S_RD_ROW)

endmodule

// ===== hw/rtl/ship_dp.sv =====
`include "ship_rrip_replacement_defines.svh"

module ship_dp #(
  parameter int WAY_COUNT  = 16,
  parameter int RRPV_WIDTH = 3,
  parameter int SIG_WIDTH  = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ship_pkg::ship_cmd_t  cmd,
  output ship_pkg::ship_stat_t stat,
  ship_req_if.sink             req,
  ship_rsp_if.source           rsp
);

  localparam int RW        = RRPV_WIDTH;
  localparam int RMAX      = (1 << RW) - 1;
  localparam int STEP      = RMAX / 3;
  localparam int WAY_W     = $clog2(WAY_COUNT);
  localparam int ROW_W     = WAY_COUNT * RW;
  localparam int SET_W     = ship_pkg::SET_W;
  localparam int SLOT_W    = SET_W + WAY_W;
  localparam int CLR_W     = (SLOT_W > SIG_WIDTH) ? SLOT_W : SIG_WIDTH;
  localparam int CTR_W     = ship_pkg::CTR_W;
  localparam logic [RW-1:0]   RMAX_V = RW'(RMAX);
  localparam logic [RW+1:0]   RMAX_X = (RW + 2)'(RMAX);
  localparam logic [RW+1:0]   STEP_X = (RW + 2)'(STEP);
  localparam logic [CLR_W-1:0] CLR_LAST = '1;

  logic [ROW_W-1:0]     row_mem [ship_pkg::SET_COUNT];
  logic [SIG_WIDTH-1:0] sig_mem [1 << SLOT_W];
  logic [CTR_W-1:0]     ctr_mem [1 << SIG_WIDTH];

  logic [CLR_W-1:0]     clr;
  logic                 query_q;
  logic                 hit_q;
  logic                 way_ok_q;
  logic [SET_W-1:0]     set_q;
  logic [WAY_W-1:0]     way_q;
  logic [SIG_WIDTH-1:0] new_sig_q;
  logic [ROW_W-1:0]     row_rd;
  logic [SIG_WIDTH-1:0] sig_rd;
  logic [CTR_W-1:0]     ctr_old;
  logic [CTR_W-1:0]     ctr_new;
  logic [WAY_COUNT-1:0] mask_q;
  logic [RW-1:0]        gap_q;
  logic [WAY_W-1:0]     victim_q;
  logic                 out_valid;
  logic [ship_pkg::WAY_IDX_W-1:0] out_way;

  logic [WAY_COUNT-1:0] mask_c;
  logic [RW-1:0]        top_c;
  logic [WAY_W-1:0]     victim_c;
  logic [ROW_W-1:0]     aged_row;
  logic [ROW_W-1:0]     upd_row;
  logic [CTR_W-1:0]     ctr_inc;
  logic [CTR_W-1:0]     ctr_dec;
  logic [CTR_W-1:0]     ctr_ins;
  logic [CTR_W-1:0]     ctr_wr;
  logic [RW+1:0]        drop;
  logic [RW-1:0]        ins_val;
  logic [SLOT_W-1:0]    slot;

  assign slot = {set_q, way_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear) begin
      clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      query_q   <= (req.cmd == ship_pkg::CMD_QUERY);
      hit_q     <= req.was_hit;
      way_ok_q  <= (32'(req.way_index) < 32'(WAY_COUNT));
      set_q     <= req.set_index;
      way_q     <= WAY_W'(req.way_index);
      new_sig_q <= req.pc[ship_pkg::PC_SHIFT +: SIG_WIDTH]
                 ^ req.paddr[ship_pkg::PADDR_SHIFT +: SIG_WIDTH];
    end
  end

  // The highest interval value is found one bit at a time from the top,
  // narrowing the set of candidate ways at each bit.
  always_comb begin
    logic [WAY_COUNT-1:0] bitv;
    mask_c   = '1;
    top_c    = '0;
    victim_c = '0;
    bitv     = '0;
    for (int b = RW - 1; b >= 0; b--) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        bitv[w] = row_rd[w * RW + b];
      end
      if (|(mask_c & bitv)) begin
        top_c[b] = 1'b1;
        mask_c   = mask_c & bitv;
      end
    end
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (mask_c[w]) begin
        victim_c = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      mask_q   <= mask_c;
      gap_q    <= RMAX_V - top_c;
      victim_q <= victim_c;
    end
  end

  always_comb begin
    logic [RW:0] sum;
    aged_row = '0;
    sum      = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      sum = {1'b0, row_rd[w * RW +: RW]} + {1'b0, gap_q};
      aged_row[w * RW +: RW] = (sum > {1'b0, RMAX_V}) ? RMAX_V : sum[RW-1:0];
    end
  end

  assign ctr_inc = (ctr_old == ship_pkg::CTR_TOP) ? ctr_old : ctr_old + 1'b1;
  assign ctr_dec = (ctr_old == ship_pkg::CTR_ZERO) ? ctr_old : ctr_old - 1'b1;
  assign ctr_ins = (new_sig_q == sig_rd) ? ctr_dec : ctr_new;
  assign ctr_wr  = hit_q ? ctr_inc : ctr_dec;
  assign drop    = (RW + 2)'(ctr_ins) * STEP_X;
  assign ins_val = (drop >= RMAX_X) ? '0 : RW'(RMAX_X - drop);

  always_comb begin
    upd_row = row_rd;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (way_q == WAY_W'(w)) begin
        upd_row[w * RW +: RW] = hit_q ? '0 : ins_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      row_mem[clr[SET_W-1:0]] <= {WAY_COUNT{RMAX_V}};
    end else if (cmd.age_wr) begin
      row_mem[set_q] <= aged_row;
    end else if (cmd.upd_wr) begin
      row_mem[set_q] <= upd_row;
    end
    if (cmd.rd_row) begin
      row_rd <= row_mem[set_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      sig_mem[clr[SLOT_W-1:0]] <= '0;
    end else if (cmd.upd_wr && !hit_q) begin
      sig_mem[slot] <= new_sig_q;
    end
    if (cmd.rd_row) begin
      sig_rd <= sig_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      ctr_mem[clr[SIG_WIDTH-1:0]] <= ship_pkg::CTR_START;
    end else if (cmd.upd_wr) begin
      ctr_mem[sig_rd] <= ctr_wr;
    end
    if (cmd.rd_ctr) begin
      ctr_old <= ctr_mem[sig_rd];
      ctr_new <= ctr_mem[new_sig_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_way <= ship_pkg::WAY_IDX_W'(victim_q);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.victim_way = out_way;

  assign stat.clear_done = (clr == CLR_LAST);
  assign stat.is_query   = query_q;
  assign stat.way_ok     = way_ok_q;
  assign stat.out_free   = !out_valid || rsp.ready;

  `SHIP_ASSERT_NEXT(a_scan_finds_top, clk, rst, cmd.scan, mask_q != '0)

endmodule

// ===== hw/rtl/ship_rrip_replacement.sv =====
// A query's victim is registered after the row read, scan and ageing states, later
// while an earlier result waits; an update reaches the memories after the row read
// and counter read states. A new transaction is taken only after the last is written
// back; an update to a way beyond WAY_COUNT frees the input after the row read. After
// reset a clearing pass over max(2**SIG_WIDTH, 2048 * 2**clog2(WAY_COUNT)) addresses
// (32768 by default) fills all memories before a transaction is taken.
module ship_rrip_replacement #(
  parameter int WAY_COUNT  = 16,
  parameter int RRPV_WIDTH = 3,
  parameter int SIG_WIDTH  = 14
) (
  input  logic       clk,
  input  logic       rst,
  ship_req_if.sink   req,
  ship_rsp_if.source rsp
);

  ship_pkg::ship_cmd_t  cmd;
  ship_pkg::ship_stat_t stat;
  logic                 ready;

  assign req.ready = ready;

  ship_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .stat      (stat),
    .ready     (ready),
    .cmd       (cmd)
  );

  ship_dp #(
    .WAY_COUNT  (WAY_COUNT),
    .RRPV_WIDTH (RRPV_WIDTH),
    .SIG_WIDTH  (SIG_WIDTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule
